// ===== sv/sgs_pkg.sv =====
// Package for the servo gait sequencer: command, mode and register index codes,
// reset values and the angle helper functions. No dependencies.
`timescale 1ns / 1ps

package sgs_pkg;

  localparam int unsigned ServoCount  = 4;
  localparam int unsigned AngleW      = 10;
  localparam int unsigned PulseW      = 10;
  localparam int unsigned PitchW      = 9;
  localparam int unsigned PeriodW     = 16;
  localparam int unsigned SwingW      = 7;
  localparam int unsigned HomeW       = 8;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned InDataW     = 16;
  localparam int unsigned OutDataW    = 48;
  localparam int unsigned SumW        = 12;

  localparam logic [PeriodW-1:0] PeriodReset   = 16'd250;
  localparam logic [SwingW-1:0]  LegSwingReset = 7'd30;
  localparam logic [SwingW-1:0]  ArmSwingReset = 7'd25;
  localparam logic [HomeW-1:0]   HomeReset     = 8'd90;
  localparam logic signed [AngleW-1:0] AngleReset = 10'sd90;

  localparam logic signed [PitchW-1:0] PitchMax    = 9'sd180;
  localparam logic signed [PitchW-1:0] PitchMin    = -9'sd180;
  localparam logic signed [SumW-1:0]   TargetMax   = 12'sd511;
  localparam logic signed [SumW-1:0]   TargetMin   = -12'sd512;
  localparam logic signed [AngleW-1:0] AngleTop    = 10'sd180;
  localparam logic [PulseW-1:0]        PulseBase   = 10'd150;

  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_PITCH    = 3'd1,
    CMD_FORWARD  = 3'd2,
    CMD_BACKWARD = 3'd3,
    CMD_STOP     = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_STOP     = 2'd0,
    MODE_FORWARD  = 2'd1,
    MODE_BACKWARD = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PERIOD    = 2'd0,
    REG_LEG_SWING = 2'd1,
    REG_ARM_SWING = 2'd2,
    REG_HOME      = 2'd3
  } reg_idx_e;

  function automatic logic signed [PitchW-1:0] sat_pitch(input logic signed [PitchW-1:0] v);
    logic signed [PitchW-1:0] r;
    r = v;
    if (v > PitchMax) r = PitchMax;
    if (v < PitchMin) r = PitchMin;
    return r;
  endfunction

  function automatic logic signed [AngleW-1:0] sat_target(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] r;
    r = v;
    if (v > TargetMax) r = TargetMax;
    if (v < TargetMin) r = TargetMin;
    return r[AngleW-1:0];
  endfunction

  // Clamp to 0..180 degrees, then 150 + angle * 5 / 2 truncated.
  function automatic logic [PulseW-1:0] pulse_of(input logic signed [AngleW-1:0] a);
    logic [AngleW-1:0] c;
    logic [AngleW-1:0] times5;
    c = a;
    if (a < 0) c = '0;
    if (a > AngleTop) c = AngleTop;
    times5 = (c << 2) + c;
    return PulseBase + (times5 >> 1);
  endfunction

endpackage

// ===== sv/servo_gait_sequencer_top.sv =====
// Top level of the four-servo gait sequencer: command decode, gait step,
// target update and the registered result beat. Depends on sgs_pkg.
`timescale 1ns / 1ps

// Channel    Direction  Fields (lowest bit first)
// s_axis     in         command[2:0], pitch_value[11:3], zero pad to 16 bits
// m_axis     out        changed_mask[3:0], pulse_left_leg, pulse_right_leg,
//                       pulse_left_arm, pulse_right_arm (10 bits each), pad to 48
// cfg        in         cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// Each beat is decoded and applied in the cycle it is accepted; its result is
// registered and offered on the next cycle, one beat per cycle sustained while m_axis is ready.
// The input is ready while the result register is empty or being drained.
// Reset restores the register defaults, stop mode, zero pitch and all angles to 90.

module servo_gait_sequencer_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [sgs_pkg::InDataW-1:0]    s_axis_tdata,   // command, pitch_value
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [sgs_pkg::OutDataW-1:0]   m_axis_tdata,   // changed_mask, four pulses
  input  logic                           cfg_we_i,
  input  logic [sgs_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [sgs_pkg::CfgDataW-1:0]   cfg_data_i
);
  import sgs_pkg::*;

  logic [PeriodW-1:0] period_q;
  logic [SwingW-1:0]  leg_swing_q, arm_swing_q;
  logic [HomeW-1:0]   home_q;

  mode_e                     mode_q, mode_d;
  logic signed [PitchW-1:0]  pitch_q, pitch_d;
  logic                      phase_q, phase_d;
  logic [PeriodW-1:0]        elapsed_q, elapsed_d;
  logic signed [AngleW-1:0]  target_q [ServoCount];
  logic signed [AngleW-1:0]  target_d [ServoCount];

  logic                      out_valid_q;
  logic [OutDataW-1:0]       out_data_q, out_data_d;

  cmd_e                      cmd;
  logic signed [PitchW-1:0]  pitch_in;
  logic                      accept;
  logic                      stance;
  logic                      step;
  logic                      dir_pos;
  logic signed [SumW-1:0]    base, leg, arm;
  logic [ServoCount-1:0]     mask;

  assign cmd      = cmd_e'(s_axis_tdata[2:0]);
  assign pitch_in = s_axis_tdata[11:3];
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept   = s_axis_tvalid && s_axis_tready;

  always_comb begin
    mode_d    = mode_q;
    pitch_d   = pitch_q;
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    target_d  = target_q;
    stance    = 1'b0;
    case (cmd)
      CMD_TICK: begin
        if (elapsed_q != {PeriodW{1'b1}}) elapsed_d = elapsed_q + 1'b1;
      end
      CMD_PITCH: begin
        pitch_d = sat_pitch(pitch_in);
        stance  = (mode_q == MODE_STOP);
      end
      CMD_FORWARD:  mode_d = MODE_FORWARD;
      CMD_BACKWARD: mode_d = MODE_BACKWARD;
      CMD_STOP: begin
        mode_d = MODE_STOP;
        stance = 1'b1;
      end
      default: ;
    endcase

    base = $signed({{(SumW-HomeW){1'b0}}, home_q})
         + $signed({{(SumW-PitchW){pitch_d[PitchW-1]}}, pitch_d});

    if (stance) begin
      for (int i = 0; i < ServoCount; i++) target_d[i] = sat_target(base);
    end

    step    = (mode_d != MODE_STOP) && (elapsed_d > period_q);
    dir_pos = !phase_q ^ (mode_d == MODE_BACKWARD);
    leg = $signed({{(SumW-SwingW){1'b0}}, leg_swing_q});
    arm = $signed({{(SumW-SwingW){1'b0}}, arm_swing_q});
    if (!dir_pos) begin
      leg = -leg;
      arm = -arm;
    end
    if (step) begin
      elapsed_d   = '0;
      phase_d     = !phase_q;
      target_d[0] = sat_target(base + leg);
      target_d[1] = sat_target(base - leg);
      target_d[2] = sat_target(base - arm);
      target_d[3] = sat_target(base + arm);
    end

    for (int i = 0; i < ServoCount; i++) mask[i] = (target_d[i] != target_q[i]);

    out_data_d = {4'b0000,
                  pulse_of(target_d[3]), pulse_of(target_d[2]),
                  pulse_of(target_d[1]), pulse_of(target_d[0]), mask};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= PeriodReset;
      leg_swing_q <= LegSwingReset;
      arm_swing_q <= ArmSwingReset;
      home_q      <= HomeReset;
      mode_q      <= MODE_STOP;
      pitch_q     <= '0;
      phase_q     <= 1'b0;
      elapsed_q   <= '0;
      for (int i = 0; i < ServoCount; i++) target_q[i] <= AngleReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_PERIOD:    period_q    <= cfg_data_i[PeriodW-1:0];
          REG_LEG_SWING: leg_swing_q <= cfg_data_i[SwingW-1:0];
          REG_ARM_SWING: arm_swing_q <= cfg_data_i[SwingW-1:0];
          REG_HOME:      home_q      <= cfg_data_i[HomeW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        mode_q    <= mode_d;
        pitch_q   <= pitch_d;
        phase_q   <= phase_d;
        elapsed_q <= elapsed_d;
        target_q  <= target_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for servo_gait_sequencer_top. A scoreboard class predicts every result
// beat from the accepted command beats and the register writes, with random stalls on both sides.
// Depends on sgs_pkg and servo_gait_sequencer_top.

module tb;
  import sgs_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;
  localparam logic [2:0]  CmdUnusedLo = 3'd5;
  localparam logic [2:0]  CmdUnusedHi = 3'd7;

  typedef struct packed {
    logic [ServoCount-1:0][PulseW-1:0] pulse;
    logic [ServoCount-1:0]             mask;
  } servo_frame_t;

  class gait_scoreboard;
    logic [PeriodW-1:0]       period;
    logic [SwingW-1:0]        leg_amp;
    logic [SwingW-1:0]        arm_amp;
    logic [HomeW-1:0]         home;
    mode_e                    mode;
    logic signed [PitchW-1:0] pitch;
    logic                     phase;
    logic [PeriodW-1:0]       elapsed;
    logic signed [AngleW-1:0] target[ServoCount];
    logic signed [AngleW-1:0] shown[ServoCount];
    servo_frame_t             frames_due[$];
    int                       errors;

    function new();
      period  = 16'd250;
      leg_amp = 7'd30;
      arm_amp = 7'd25;
      home    = 8'd90;
      mode    = MODE_STOP;
      pitch   = '0;
      phase   = 1'b0;
      elapsed = '0;
      errors  = 0;
      foreach (target[i]) begin
        target[i] = 10'sd90;
        shown[i]  = 10'sd90;
      end
    endfunction

    function int pending();
      return frames_due.size();
    endfunction

    function void set_reg(reg_idx_e idx, logic [CfgDataW-1:0] v);
      case (idx)
        REG_PERIOD:    period  = v[PeriodW-1:0];
        REG_LEG_SWING: leg_amp = v[SwingW-1:0];
        REG_ARM_SWING: arm_amp = v[SwingW-1:0];
        REG_HOME:      home    = v[HomeW-1:0];
        default: ;
      endcase
    endfunction

    function logic signed [AngleW-1:0] limit_angle(int v);
      if (v < -512) v = -512;
      if (v > 511) v = 511;
      return v[AngleW-1:0];
    endfunction

    function logic [PulseW-1:0] pulse_count(logic signed [AngleW-1:0] a);
      int c;
      logic [PulseW-1:0] r;
      c = a;
      if (c < 0) c = 0;
      if (c > 180) c = 180;
      r = PulseW'(150 + (c * 5) / 2);
      return r;
    endfunction

    function void take_stance();
      foreach (target[i]) target[i] = limit_angle(int'(home) + int'(pitch));
    endfunction

    function void take_command(logic [2:0] cmd, logic [PitchW-1:0] raw);
      int pv;
      int base;
      int leg;
      int arm;
      servo_frame_t f;
      pv = int'($signed(raw));
      case (cmd)
        CMD_TICK: if (elapsed != '1) elapsed = elapsed + 1'b1;
        CMD_PITCH: begin
          if (pv < -180) pv = -180;
          if (pv > 180) pv = 180;
          pitch = pv[PitchW-1:0];
          if (mode == MODE_STOP) take_stance();
        end
        CMD_FORWARD: mode = MODE_FORWARD;
        CMD_BACKWARD: mode = MODE_BACKWARD;
        CMD_STOP: begin
          mode = MODE_STOP;
          take_stance();
        end
        default: ;
      endcase
      if (mode != MODE_STOP && elapsed > period) begin
        elapsed = '0;
        phase = ~phase;
        base = int'(home) + int'(pitch);
        leg = phase ? int'(leg_amp) : -int'(leg_amp);
        arm = phase ? int'(arm_amp) : -int'(arm_amp);
        if (mode == MODE_BACKWARD) begin
          leg = -leg;
          arm = -arm;
        end
        target[0] = limit_angle(base + leg);
        target[1] = limit_angle(base - leg);
        target[2] = limit_angle(base - arm);
        target[3] = limit_angle(base + arm);
      end
      f = '0;
      foreach (shown[i]) begin
        if (shown[i] != target[i]) begin
          shown[i] = target[i];
          f.mask[i] = 1'b1;
        end
        f.pulse[i] = pulse_count(shown[i]);
      end
      frames_due.push_back(f);
    endfunction

    function void check_frame(logic [OutDataW-1:0] data);
      servo_frame_t got;
      servo_frame_t want;
      int i;
      got = data[$bits(servo_frame_t)-1:0];
      if (frames_due.size() == 0) begin
        $display("%0t: result beat with none expected, expected nothing, actual %h", $time, data);
        errors++;
        return;
      end
      want = frames_due.pop_front();
      if (got.mask != want.mask) begin
        $display("%0t: changed_mask expected %h actual %h", $time, want.mask, got.mask);
        errors++;
      end
      for (i = 0; i < ServoCount; i++) begin
        if (got.pulse[i] != want.pulse[i]) begin
          $display("%0t: pulse %0d expected %0d actual %0d", $time, i, want.pulse[i],
                   got.pulse[i]);
          errors++;
        end
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic                  cfg_we_i;
  logic [CfgIdxW-1:0]    cfg_idx_i;
  logic [CfgDataW-1:0]   cfg_data_i;

  gait_scoreboard sb;
  bit             idle_on = 1'b1;
  bit             hold_req = 1'b0;
  int unsigned    cycles = 0;

  servo_gait_sequencer_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_frame(m_axis_tdata);
  end

  // The result side stalls in random bursts, and once for a long stretch on request.
  initial begin
    int gap;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        gap = $urandom_range(1, 16);
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_cmd(input logic [2:0] cmd, input logic [PitchW-1:0] raw);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW - 3 - PitchW){1'b0}}, raw, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_command(cmd, raw);
  endtask

  task automatic send_random_cmd();
    int r;
    logic [2:0] cmd;
    r = $urandom_range(0, 99);
    if (r < 60) cmd = CMD_TICK;
    else if (r < 70) cmd = CMD_PITCH;
    else if (r < 78) cmd = CMD_FORWARD;
    else if (r < 86) cmd = CMD_BACKWARD;
    else if (r < 95) cmd = CMD_STOP;
    else cmd = 3'($urandom_range(CmdUnusedLo, CmdUnusedHi));
    send_cmd(cmd, 9'($urandom));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_reg(input reg_idx_e idx, input logic [CfgDataW-1:0] v);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic set_all_regs(input logic [CfgDataW-1:0] period, input logic [CfgDataW-1:0] leg,
                              input logic [CfgDataW-1:0] arm, input logic [CfgDataW-1:0] home);
    set_reg(REG_PERIOD, period);
    set_reg(REG_LEG_SWING, leg);
    set_reg(REG_ARM_SWING, arm);
    set_reg(REG_HOME, home);
  endtask

  initial begin
    int ph;
    int n;
    logic [2:0] code;
    sb = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_PERIOD;
    cfg_data_i    = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: pitch saturation, unused codes and mode changes.
    send_cmd(CMD_TICK, '0);
    send_cmd(CMD_PITCH, 9'h0FF);
    send_cmd(CMD_PITCH, 9'h100);
    send_cmd(CMD_PITCH, 9'sd180);
    send_cmd(CMD_PITCH, -9'sd180);
    send_cmd(CMD_PITCH, '0);
    for (code = CmdUnusedLo; code != 3'd0; code++) send_cmd(code, 9'($urandom));
    send_cmd(CMD_FORWARD, '0);
    send_cmd(CMD_BACKWARD, '0);
    send_cmd(CMD_STOP, '0);
    wait_idle();

    // Period zero with the widest leg swing and no arm swing; the walk command steps at once.
    set_all_regs(16'd0, 16'd127, 16'd0, 16'd255);
    send_cmd(CMD_PITCH, 9'sd180);
    send_cmd(CMD_FORWARD, '0);
    send_cmd(CMD_TICK, '0);
    send_cmd(CMD_TICK, '0);
    send_cmd(CMD_PITCH, -9'sd100);
    send_cmd(CMD_TICK, '0);
    send_cmd(CMD_BACKWARD, '0);
    send_cmd(CMD_TICK, '0);
    send_cmd(CmdUnusedHi, 9'h1FF);
    send_cmd(CMD_STOP, '0);
    wait_idle();

    set_all_regs(16'd1, 16'd0, 16'd90, 16'd0);
    send_cmd(CMD_PITCH, -9'sd180);
    send_cmd(CMD_FORWARD, '0);
    repeat (3) send_cmd(CMD_TICK, '0);
    send_cmd(CMD_STOP, '0);
    wait_idle();

    for (ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_all_regs(16'd0, 16'd127, 16'd127, 16'd255);
        1: set_all_regs(16'hFFFF, 16'd0, 16'd0, 16'd0);
        default: begin
          set_all_regs(($urandom_range(0, 9) == 0) ? 16'($urandom_range(41, 400))
                                                   : 16'($urandom_range(1, 40)),
                       16'($urandom_range(0, 127)), 16'($urandom_range(0, 127)),
                       16'($urandom_range(0, 255)));
        end
      endcase
      if (ph == 3) hold_req = 1'b1;
      if (ph >= 8) idle_on = 1'b0;
      for (n = 0; n < 125; n++) begin
        if (ph == 4 && n == 60) wait_idle();
        send_random_cmd();
      end
      wait_idle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/sgs_pkg.sv
sv/servo_gait_sequencer_top.sv
sim/tb.sv
